### rtl/core/price_level_order_book_defines.svh
// ----------------------------------------------------------------------------
// price level order book assertion macros
// shared property wrappers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH

// same-cycle implication
`define PLOB_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("order book check failed");

// next-cycle implication
`define PLOB_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("order book check failed");

`endif

### rtl/core/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// shared widths, codes and types of the price level order book
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int unsigned LEVELS     = 64;
  localparam int unsigned PRICE_BITS = 32;
  localparam int unsigned QTY_BITS   = 48;
  localparam int unsigned CNT_W      = $clog2(LEVELS + 1);

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [QTY_BITS-1:0]   qty_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic {
    SIDE_BID = 1'b0,
    SIDE_ASK = 1'b1
  } side_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_e;

  // per-cycle command broadcast to every cell of one side
  typedef struct packed {
    logic ins;
    logic del;
    logic mod;
  } cmd_t;

  typedef struct packed {
    price_t price;
    qty_t   qty;
  } level_t;

endpackage

### rtl/core/plob_cell.sv
// ----------------------------------------------------------------------------
// plob_cell
// one price level slot of a sorted chain; shifts with its neighbors
// ----------------------------------------------------------------------------
module plob_cell import plob_pkg::*; (
  input  logic   clk_i,
  input  cmd_t   cmd_i,
  input  logic   is_ask_i,
  input  logic   valid_i,
  input  level_t new_i,
  input  level_t prev_i,
  input  level_t next_i,
  input  logic   prev_worse_i,
  output logic   worse_o,
  output logic   match_o,
  output level_t level_o
);

  level_t level_q, level_d;
  logic   worse_eq;

  // bids kept descending, asks ascending; empty slots count as worse
  always_comb begin
    worse_eq = !valid_i ||
               (is_ask_i ? (level_q.price >= new_i.price) : (level_q.price <= new_i.price));
    match_o  = valid_i && (level_q.price == new_i.price);
    worse_o  = worse_eq && !match_o;
  end

  always_comb begin
    level_d = level_q;
    if (cmd_i.ins && worse_o) begin
      level_d = prev_worse_i ? prev_i : new_i;
    end else if (cmd_i.del && worse_eq) begin
      level_d = next_i;
    end else if (cmd_i.mod && match_o) begin
      level_d.qty = new_i.qty;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign level_o = level_q;

endmodule

### rtl/core/plob_side.sv
// ----------------------------------------------------------------------------
// plob_side
// one side of the book: a chain of level cells kept in price order
// ----------------------------------------------------------------------------
module plob_side import plob_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   is_ask_i,
  input  logic   update_i,
  input  logic   clear_i,
  input  level_t new_i,
  output logic   found_o,
  output qty_t   found_qty_o,
  output logic   dropped_o,
  output price_t best_o,
  output cnt_t   count_o
);

  cnt_t   count_q, count_d;
  cmd_t   cmd;
  level_t lvl   [LEVELS];
  logic   worse [LEVELS];
  logic   match [LEVELS];
  logic   upd_set;
  logic   is_full;

  always_comb begin
    found_o     = 1'b0;
    found_qty_o = '0;
    for (int unsigned k = 0; k < LEVELS; k++) begin
      found_o     = found_o | match[k];
      found_qty_o = found_qty_o | (lvl[k].qty & {QTY_BITS{match[k]}});
    end
  end

  always_comb begin
    upd_set   = update_i && (new_i.price != '0) && (new_i.qty != '0);
    is_full   = (count_q == CNT_W'(LEVELS));
    cmd.ins   = upd_set && !found_o && !is_full;
    cmd.mod   = upd_set && found_o;
    cmd.del   = update_i && (new_i.price != '0) && (new_i.qty == '0) && found_o;
    dropped_o = upd_set && !found_o && is_full;
  end

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    level_t prev_lvl, next_lvl;
    logic   prev_worse;

    if (i == 0) begin : g_head
      assign prev_lvl   = new_i;
      assign prev_worse = 1'b0;
    end else begin : g_body
      assign prev_lvl   = lvl[i-1];
      assign prev_worse = worse[i-1];
    end

    if (i == LEVELS - 1) begin : g_tail
      assign next_lvl = lvl[i];
    end else begin : g_link
      assign next_lvl = lvl[i+1];
    end

    plob_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .is_ask_i     (is_ask_i),
      .valid_i      (count_q > CNT_W'(i)),
      .new_i        (new_i),
      .prev_i       (prev_lvl),
      .next_i       (next_lvl),
      .prev_worse_i (prev_worse),
      .worse_o      (worse[i]),
      .match_o      (match[i]),
      .level_o      (lvl[i])
    );
  end

  assign best_o  = lvl[0].price;
  assign count_o = count_q;

endmodule

### rtl/core/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book
// level-2 book with bid and ask tables held as sorted chains of level cells
// ----------------------------------------------------------------------------
// latency: a word taken at the start edge is applied in the next cycle and
//   its result shows with done_o in the cycle after that
// pacing: no new word is taken during the single update cycle of the cell chains;
//   the next may be taken in the result cycle; busy is high in the update cycle
// reset: both level counts clear at once, the level cells hold no reset value
// the receiver cannot stall: each result is valid for the one done_o cycle
module price_level_order_book import plob_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic                  side_i,
  input  logic [PRICE_BITS-1:0] level_price_i,
  input  logic [QTY_BITS-1:0]   level_quantity_i,
  output logic                  done_o,
  output logic [PRICE_BITS-1:0] best_bid_o,
  output logic [PRICE_BITS-1:0] best_ask_o,
  output logic signed [PRICE_BITS:0] bid_ask_spread_o,
  output logic [PRICE_BITS:0]   mid_price_doubled_o,
  output logic [CNT_W-1:0]      bid_levels_o,
  output logic [CNT_W-1:0]      ask_levels_o,
  output logic [QTY_BITS-1:0]   quantity_at_price_o,
  output logic                  side_full_o
);

  state_e state_q, state_d;
  logic   accept;

  // captured word
  op_e    op_q;
  side_e  side_q;
  level_t word_q;

  // side interfaces
  logic   exec;
  logic   bid_found, ask_found;
  qty_t   bid_fqty, ask_fqty;
  logic   bid_drop, ask_drop;
  price_t bid_best, ask_best;
  cnt_t   bid_count, ask_count;

  // result registers filled in the update cycle
  qty_t   at_price_q, at_price_d;
  logic   full_q, full_d;
  logic   sel_found, sel_drop;
  qty_t   sel_fqty;

  assign accept = start && !busy;

  // fsm: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_RESP: begin
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fsm: outputs
  always_comb begin
    busy   = 1'b0;
    done_o = 1'b0;
    exec   = 1'b0;
    case (state_q)
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= op_e'(operation_i);
      side_q       <= side_e'(side_i);
      word_q.price <= level_price_i;
      word_q.qty   <= level_quantity_i;
    end
  end

  plob_side u_bid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .is_ask_i    (1'b0),
    .update_i    (exec && (op_q == OP_UPDATE) && (side_q == SIDE_BID)),
    .clear_i     (exec && (op_q == OP_CLEAR)),
    .new_i       (word_q),
    .found_o     (bid_found),
    .found_qty_o (bid_fqty),
    .dropped_o   (bid_drop),
    .best_o      (bid_best),
    .count_o     (bid_count)
  );

  plob_side u_ask (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .is_ask_i    (1'b1),
    .update_i    (exec && (op_q == OP_UPDATE) && (side_q == SIDE_ASK)),
    .clear_i     (exec && (op_q == OP_CLEAR)),
    .new_i       (word_q),
    .found_o     (ask_found),
    .found_qty_o (ask_fqty),
    .dropped_o   (ask_drop),
    .best_o      (ask_best),
    .count_o     (ask_count)
  );

  // quantity after the word: an accepted set leaves its quantity, a delete, a
  // dropped insert or a clear leaves nothing, a query reads what the chain holds
  always_comb begin
    sel_found  = (side_q == SIDE_ASK) ? ask_found : bid_found;
    sel_fqty   = (side_q == SIDE_ASK) ? ask_fqty  : bid_fqty;
    sel_drop   = (side_q == SIDE_ASK) ? ask_drop  : bid_drop;
    at_price_d = '0;
    full_d     = 1'b0;
    case (op_q)
      OP_UPDATE: begin
        full_d = sel_drop;
        if ((word_q.price != '0) && !sel_drop) begin
          at_price_d = word_q.qty;
        end
      end
      OP_CLEAR: begin
        at_price_d = '0;
      end
      default: begin
        // query and the reserved code read without changing anything
        at_price_d = sel_found ? sel_fqty : '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      at_price_q <= at_price_d;
      full_q     <= full_d;
    end
  end

  // best prices sit in the head cell of each chain
  always_comb begin
    best_bid_o          = (bid_count != '0) ? bid_best : '0;
    best_ask_o          = (ask_count != '0) ? ask_best : '0;
    bid_ask_spread_o    = '0;
    mid_price_doubled_o = '0;
    if ((bid_count != '0) && (ask_count != '0)) begin
      bid_ask_spread_o    = $signed({1'b0, ask_best} - {1'b0, bid_best});
      mid_price_doubled_o = {1'b0, bid_best} + {1'b0, ask_best};
    end
  end

  assign bid_levels_o        = bid_count;
  assign ask_levels_o        = ask_count;
  assign quantity_at_price_o = at_price_q;
  assign side_full_o         = full_q;

endmodule

### rtl/core/plob_checker.sv
// ----------------------------------------------------------------------------
// plob_checker
// port-level checks of the price level order book, bound to the top level
// ----------------------------------------------------------------------------
`include "price_level_order_book_defines.svh"

module plob_checker import plob_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic signed [PRICE_BITS:0] bid_ask_spread_o,
  input logic [PRICE_BITS:0]   mid_price_doubled_o,
  input logic [CNT_W-1:0]      bid_levels_o,
  input logic [CNT_W-1:0]      ask_levels_o,
  input logic [QTY_BITS-1:0]   quantity_at_price_o,
  input logic                  side_full_o
);

  // a taken word keeps the block busy for its update cycle
  `PLOB_ASSERT_NXT(a_take_busy, start && !busy, busy)
  // every update cycle is followed by exactly one result
  `PLOB_ASSERT_NXT(a_busy_done, busy, done_o && !busy)
  // level counts never pass the table depth
  `PLOB_ASSERT_IMP(a_count_max, done_o,
                   (bid_levels_o <= CNT_W'(LEVELS)) && (ask_levels_o <= CNT_W'(LEVELS)))
  // an empty side reports no spread and no mid price
  `PLOB_ASSERT_IMP(a_empty_zero, done_o && ((bid_levels_o == '0) || (ask_levels_o == '0)),
                   (bid_ask_spread_o == '0) && (mid_price_doubled_o == '0))
  // a dropped insert leaves no quantity at its price
  `PLOB_ASSERT_IMP(a_drop_qty, done_o && side_full_o, quantity_at_price_o == '0)

endmodule

bind price_level_order_book plob_checker u_plob_checker (.*);

### verif/price_level_order_book_tb.sv
// ----------------------------------------------------------------------------
// price_level_order_book_tb
// self-checking bench for the level-2 book: a queue of command words feeds a
// clocked driver, a shadow book predicts every result and a clocked monitor
// compares each done_o word field by field against the oldest prediction
// ----------------------------------------------------------------------------
module price_level_order_book_tb import plob_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // one command word as queued for the driver, with its idle gap afterwards
  typedef struct {
    op_e         op;
    side_e       side;
    price_t      price;
    qty_t        qty;
    bit          drain;  // hold until every result is back before sending
    int unsigned gap;
  } book_word_t;

  // what the book reports after one word
  typedef struct {
    price_t                   best_bid;
    price_t                   best_ask;
    logic signed [PRICE_BITS:0] spread;
    logic [PRICE_BITS:0]      mid2;
    cnt_t                     bid_n;
    cnt_t                     ask_n;
    qty_t                     qty_at;
    logic                     full;
  } book_snapshot_t;

  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                operation_i = '0;
  logic                      side_i = 1'b0;
  logic [PRICE_BITS-1:0]     level_price_i = '0;
  logic [QTY_BITS-1:0]       level_quantity_i = '0;
  logic                      done_o;
  logic [PRICE_BITS-1:0]     best_bid_o;
  logic [PRICE_BITS-1:0]     best_ask_o;
  logic signed [PRICE_BITS:0] bid_ask_spread_o;
  logic [PRICE_BITS:0]       mid_price_doubled_o;
  logic [CNT_W-1:0]          bid_levels_o;
  logic [CNT_W-1:0]          ask_levels_o;
  logic [QTY_BITS-1:0]       quantity_at_price_o;
  logic                      side_full_o;

  price_level_order_book u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .operation_i        (operation_i),
    .side_i             (side_i),
    .level_price_i      (level_price_i),
    .level_quantity_i   (level_quantity_i),
    .done_o             (done_o),
    .best_bid_o         (best_bid_o),
    .best_ask_o         (best_ask_o),
    .bid_ask_spread_o   (bid_ask_spread_o),
    .mid_price_doubled_o(mid_price_doubled_o),
    .bid_levels_o       (bid_levels_o),
    .ask_levels_o       (ask_levels_o),
    .quantity_at_price_o(quantity_at_price_o),
    .side_full_o        (side_full_o)
  );

  always #1 clk_i = ~clk_i;

  // ---- shadow book and prediction ------------------------------------------

  // one map per side, price to quantity; map size is the level count and the
  // sorted key order gives best bid as the last key and best ask as the first
  qty_t level_book[2][price_t];

  function automatic book_snapshot_t apply_book_word(input book_word_t w);
    book_snapshot_t s;
    int     sd;
    price_t k;
    s  = '{default: '0};
    sd = int'(w.side);
    case (w.op)
      OP_UPDATE: begin
        // zero price is reserved and never touches the book
        if (w.price != '0) begin
          if (w.qty == '0) begin
            // delete of an absent price is silently ignored
            if (level_book[sd].exists(w.price)) level_book[sd].delete(w.price);
          end else if (level_book[sd].exists(w.price)) begin
            // modify still works when the side is full
            level_book[sd][w.price] = w.qty;
          end else if (level_book[sd].num() >= LEVELS) begin
            s.full = 1'b1;
          end else begin
            level_book[sd][w.price] = w.qty;
          end
        end
      end
      OP_CLEAR: begin
        level_book[0].delete();
        level_book[1].delete();
      end
      default: ;  // query and the reserved code leave the book alone
    endcase
    if (w.op != OP_CLEAR && w.price != '0 && level_book[sd].exists(w.price))
      s.qty_at = level_book[sd][w.price];
    if (level_book[int'(SIDE_BID)].last(k)) s.best_bid = k;
    if (level_book[int'(SIDE_ASK)].first(k)) s.best_ask = k;
    // spread and mid only when both sides hold a level; crossed goes negative
    if (s.best_bid != '0 && s.best_ask != '0) begin
      s.spread = {1'b0, s.best_ask} - {1'b0, s.best_bid};
      s.mid2   = {1'b0, s.best_bid} + {1'b0, s.best_ask};
    end
    s.bid_n = cnt_t'(level_book[int'(SIDE_BID)].num());
    s.ask_n = cnt_t'(level_book[int'(SIDE_ASK)].num());
    return s;
  endfunction

  // ---- stimulus generation -------------------------------------------------

  book_word_t     word_q[$];
  book_snapshot_t snapshot_q[$];
  int unsigned    words_total = 0;
  int unsigned    busy_run = 0;  // words left in a stretch without idling

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (busy_run > 0) begin
      busy_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      busy_run = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(input op_e op, input side_e side, input price_t price,
                          input qty_t qty, input bit drain = 1'b0);
    book_word_t w;
    w.op    = op;
    w.side  = side;
    w.price = price;
    w.qty   = qty;
    w.drain = drain;
    w.gap   = pick_gap();
    word_q.push_back(w);
    words_total++;
  endtask

  // mostly small lot sizes, sometimes the full width or the maximum
  function automatic qty_t rand_qty();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return qty_t'({$urandom, $urandom});
    if (r == 1) return '1;
    return qty_t'($urandom_range(1, 1000));
  endfunction

  // bids sit at or below the base, asks from 3 below it upward, overlapping so
  // that the book crosses now and then
  function automatic price_t near_price(input price_t base, input side_e side);
    if (side == SIDE_BID) return base - price_t'($urandom_range(0, 24));
    return base + price_t'($urandom_range(0, 24)) - price_t'($urandom_range(0, 3));
  endfunction

  function automatic side_e rand_side();
    return side_e'($urandom_range(0, 1));
  endfunction

  // snapshot: clear then a run of level updates around one price
  task automatic add_snapshot();
    price_t base;
    side_e  sd;
    int     n;
    base = price_t'($urandom_range(64, 32'hFFFF_FFBF));
    add_word(OP_CLEAR, rand_side(), price_t'($urandom), rand_qty());
    n = $urandom_range(5, 30);
    repeat (n) begin
      sd = rand_side();
      add_word(OP_UPDATE, sd, near_price(base, sd), rand_qty());
    end
  endtask

  // fill one side past LEVELS, modify and query while full, then delete and insert again
  task automatic add_fill();
    price_t base;
    side_e  sd;
    int     extra;
    sd    = rand_side();
    base  = price_t'($urandom_range(1000, 32'hF000_0000));
    extra = $urandom_range(2, 6);
    add_word(OP_CLEAR, sd, '0, '0);
    for (int i = 0; i < LEVELS + extra; i++)
      add_word(OP_UPDATE, sd, base + price_t'(3 * i), rand_qty());
    add_word(OP_UPDATE, sd, base + price_t'(15), rand_qty());
    add_word(OP_QUERY, sd, base + price_t'(15), '0);
    add_word(OP_QUERY, sd, base + price_t'(3 * LEVELS), '0);
    repeat ($urandom_range(1, 4))
      add_word(OP_UPDATE, rand_side() == SIDE_BID ? sd : side_e'(~sd),
               base + price_t'(3 * $urandom_range(0, LEVELS - 1)), '0);
    add_word(OP_UPDATE, sd, base + price_t'(3 * LEVELS + 1), rand_qty());
    add_word(OP_UPDATE, sd, base + price_t'(3 * LEVELS + 2), rand_qty());
  endtask

  // free mix of updates, deletes, queries and the odd clear or reserved code
  task automatic add_mix();
    price_t base;
    side_e  sd;
    int     n;
    int unsigned r;
    bit     drain;
    base = price_t'($urandom_range(64, 32'hFFFF_FFBF));
    n = $urandom_range(10, 40);
    repeat (n) begin
      sd    = rand_side();
      r     = $urandom_range(0, 99);
      drain = ($urandom_range(0, 49) == 0);
      if (r < 40)
        add_word(OP_UPDATE, sd, near_price(base, sd), rand_qty(), drain);
      else if (r < 55)
        add_word(OP_UPDATE, sd, near_price(base, sd), '0, drain);
      else if (r < 60)
        add_word(OP_UPDATE, sd, price_t'($urandom), qty_t'({$urandom, $urandom}), drain);
      else if (r < 62)
        add_word(OP_UPDATE, sd, '0, rand_qty(), drain);
      else if (r < 88)
        add_word(OP_QUERY, sd, near_price(base, sd), qty_t'({$urandom, $urandom}), drain);
      else if (r < 94)
        add_word(OP_RSVD, sd, near_price(base, sd), qty_t'({$urandom, $urandom}), drain);
      else
        add_word(OP_CLEAR, sd, price_t'($urandom), qty_t'({$urandom, $urandom}), drain);
    end
  endtask

  // ---- driver --------------------------------------------------------------

  book_word_t  cur_word;
  int unsigned gap_left = 0;
  int unsigned words_sent = 0;         // bumped with nonblocking assignments
  int unsigned snapshots_checked = 0;  // same, so reads see the pre-edge count

  always @(posedge clk_i) begin : driver
    bit accepting;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      accepting = start && !busy;
      if (accepting) begin
        snapshot_q.push_back(apply_book_word(cur_word));
        words_sent <= words_sent + 1;
      end
      // the bus is free to carry the next word
      if (!start || accepting) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_q.size() == 0) begin
          start <= 1'b0;
        end else if (word_q[0].drain && (accepting || words_sent != snapshots_checked)) begin
          // hold off until the book has answered everything
          start <= 1'b0;
        end else begin
          cur_word = word_q.pop_front();
          gap_left = cur_word.gap;
          start            <= 1'b1;
          operation_i      <= cur_word.op;
          side_i           <= cur_word.side;
          level_price_i    <= cur_word.price;
          level_quantity_i <= cur_word.qty;
        end
      end
    end
  end

  // ---- monitor -------------------------------------------------------------

  int unsigned errors = 0;

  task automatic check_field(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    book_snapshot_t want;
    if (rst_ni && done_o) begin
      if (snapshots_checked >= words_sent) begin
        errors++;
        $display("%0t: done_o expected none actual word", $time);
      end else begin
        want = snapshot_q.pop_front();
        check_field("best_bid", 64'(want.best_bid), 64'(best_bid_o));
        check_field("best_ask", 64'(want.best_ask), 64'(best_ask_o));
        check_field("bid_ask_spread", 64'(unsigned'(want.spread)),
                    64'(unsigned'(bid_ask_spread_o)));
        check_field("mid_price_doubled", 64'(want.mid2), 64'(mid_price_doubled_o));
        check_field("bid_levels", 64'(want.bid_n), 64'(bid_levels_o));
        check_field("ask_levels", 64'(want.ask_n), 64'(ask_levels_o));
        check_field("quantity_at_price", 64'(want.qty_at), 64'(quantity_at_price_o));
        check_field("side_full", 64'(want.full), 64'(side_full_o));
        snapshots_checked <= snapshots_checked + 1;
      end
    end
  end

  // ---- watchdog ------------------------------------------------------------

  int unsigned quiet_cycles = 0;

  // an accepted word, or a result that answers a pending word, counts as progress
  always @(posedge clk_i) begin
    if ((start && !busy) || (done_o && snapshots_checked < words_sent)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin : sequencer
    int unsigned directed_n;
    int unsigned r;

    // directed words: extremes, every code and the corner cases
    add_word(OP_QUERY, SIDE_BID, price_t'(100), '0);               // empty book
    add_word(OP_UPDATE, SIDE_BID, price_t'(1), qty_t'(1));          // lowest price
    add_word(OP_UPDATE, SIDE_ASK, '1, '1);                          // top price, max lots
    add_word(OP_QUERY, SIDE_ASK, '1, '0);
    add_word(OP_UPDATE, SIDE_BID, '0, qty_t'(5));                   // zero price ignored
    add_word(OP_QUERY, SIDE_BID, '0, '1);                           // zero price query
    add_word(OP_UPDATE, SIDE_BID, price_t'(1), {QTY_BITS/2{2'b01}}); // modify
    add_word(OP_UPDATE, SIDE_ASK, price_t'(77), '0);                // delete absent
    add_word(OP_UPDATE, SIDE_ASK, price_t'(50), {QTY_BITS/2{2'b10}});
    add_word(OP_UPDATE, SIDE_BID, price_t'(60), qty_t'(3));         // crossed book
    add_word(OP_RSVD, SIDE_ASK, price_t'(50), qty_t'(9));           // reserved code
    add_word(OP_UPDATE, SIDE_BID, price_t'(60), '0);                // delete present
    add_word(OP_UPDATE, SIDE_ASK, '1, '0);
    add_word(OP_CLEAR, SIDE_ASK, price_t'(50), qty_t'(9), 1'b1);    // clear after a drain
    add_word(OP_QUERY, SIDE_ASK, price_t'(50), '0);
    add_word(OP_UPDATE, SIDE_BID, '1, qty_t'(1));                   // widest mid
    add_word(OP_UPDATE, SIDE_ASK, '1, qty_t'(2));
    add_word(OP_UPDATE, SIDE_BID, {1'b1, {PRICE_BITS-1{1'b0}}}, '1);
    add_word(OP_UPDATE, SIDE_ASK, price_t'(2), qty_t'(7));          // strongly negative spread
    add_word(OP_QUERY, SIDE_BID, '1, '0);
    add_word(OP_CLEAR, SIDE_BID, '0, '0);
    directed_n = words_total;

    // random part: mostly snapshots and mixed traffic, with some side fills
    while (words_total < directed_n + RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 25) add_snapshot();
      else if (r < 33) add_fill();
      else add_mix();
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for every word to go out and every result to come back
    while (words_sent != words_total || snapshots_checked != words_total)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && snapshot_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/plob_pkg.sv
rtl/core/plob_cell.sv
rtl/core/plob_side.sv
rtl/core/price_level_order_book.sv
rtl/core/plob_checker.sv
verif/price_level_order_book_tb.sv
